/* rtl/core/mjdc_pkg.sv */
// ----------------------------------------------------------------------------
// mjdc_pkg
// Shared types and constants for the MJD to calendar converter.
// ----------------------------------------------------------------------------
`default_nettype none

package mjdc_pkg;

  // pipeline depth, one register rank per stage
  localparam int NUM_STAGES = 5;

  // field widths
  localparam int DAYS_W   = 17;
  localparam int DFRAC_W  = 32;
  localparam int YEAR_W   = 12;
  localparam int MONTH_W  = 4;
  localparam int DOM_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SEC_W    = 26;

  // date arithmetic widths
  localparam int B_W  = 22;  // b = days + 2401538
  localparam int N_W  = 28;  // 100b - 12210
  localparam int C_W  = 13;  // c, below 8192
  localparam int G_W  = 9;   // b - d, 123..488
  localparam int E_W  = 4;   // e, 4..15
  localparam int ET_W = 23;  // 10000 (b - d)

  localparam logic [B_W-1:0]  B_OFFSET     = 22'd2401538;
  localparam logic [N_W-1:0]  C_NUM_OFFSET = 28'd12210;
  localparam logic [N_W-1:0]  C_DIV        = 28'd36525;
  // floor(2^32 / 36525): estimate of c is exact or one low
  localparam logic [16:0]     C_RECIP      = 17'((64'd1 << 32) / 64'd36525);
  localparam logic [ET_W-1:0] E_DIV        = 23'd306001;
  // 10000 * floor(2^32 / 306001): estimate of e is exact or one low
  localparam logic [27:0]     E_RECIP_K    = 28'(64'd10000 * ((64'd1 << 32) / 64'd306001));
  localparam logic [C_W-1:0]  YEAR_OFFSET  = 13'd4715;

  // per-stage load enables, from the valid chain to the datapaths
  typedef struct packed {
    logic [NUM_STAGES-1:0] stage;
  } mjdc_load_t;

  // floor(30.6001 * e)
  function automatic logic [G_W-1:0] mjdc_day_offset(input logic [E_W-1:0] e);
    logic [G_W-1:0] ofs;
    unique case (e)
      4'd0:    ofs = 9'd0;
      4'd1:    ofs = 9'd30;
      4'd2:    ofs = 9'd61;
      4'd3:    ofs = 9'd91;
      4'd4:    ofs = 9'd122;
      4'd5:    ofs = 9'd153;
      4'd6:    ofs = 9'd183;
      4'd7:    ofs = 9'd214;
      4'd8:    ofs = 9'd244;
      4'd9:    ofs = 9'd275;
      4'd10:   ofs = 9'd306;
      4'd11:   ofs = 9'd336;
      4'd12:   ofs = 9'd367;
      4'd13:   ofs = 9'd397;
      4'd14:   ofs = 9'd428;
      default: ofs = 9'd459;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/mjd_to_calendar.sv */
// Throughput: one beat per cycle while the output is not stalled; the reciprocal
// multipliers of the date path and the constant multiplies of the time path are each one stage.
// Stages hold individually, so bubbles close up under back-pressure.
// Reset: synchronous, active low; clears all stage valid bits, data is not reset.
// ----------------------------------------------------------------------------
// mjd_to_calendar
// Modified Julian Date (days + Q0.FRACTION_BITS day fraction) to Gregorian
// year, month, day, hour, minute and seconds in 2^-SECOND_FRACTION_BITS s.
// ----------------------------------------------------------------------------
`default_nettype none

module mjd_to_calendar #(
  parameter int FRACTION_BITS        = 32,
  parameter int SECOND_FRACTION_BITS = 20
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input beats
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [mjdc_pkg::DAYS_W-1:0]    in_mjd_days,
  input  logic [mjdc_pkg::DFRAC_W-1:0]   in_day_fraction,
  // output beats
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [mjdc_pkg::YEAR_W-1:0]    out_year,
  output logic [mjdc_pkg::MONTH_W-1:0]   out_month,
  output logic [mjdc_pkg::DOM_W-1:0]     out_day_of_month,
  output logic [mjdc_pkg::HOUR_W-1:0]    out_hour,
  output logic [mjdc_pkg::MINUTE_W-1:0]  out_minute,
  output logic [mjdc_pkg::SEC_W-1:0]     out_second_fixed
);
  import mjdc_pkg::*;

  // Valid chain. A stage loads when it is empty or the stage after it
  // loads too; the last stage loads when it is empty or its beat is taken.
  logic [NUM_STAGES-1:0] valid_r;
  logic [NUM_STAGES-1:0] valid_nxt;
  mjdc_load_t            ld;

  always_comb begin
    ld.stage[NUM_STAGES-1] = !valid_r[NUM_STAGES-1] || !out_stall;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ld.stage[i] = !valid_r[i] || ld.stage[i+1];
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_STAGES; i++) begin
      if (ld.stage[i]) begin
        valid_nxt[i] = (i == 0) ? in_valid : valid_r[(i == 0) ? 0 : i - 1];
      end else begin
        valid_nxt[i] = valid_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // stall only once every stage is full and the output is held
  assign in_stall  = !ld.stage[0];
  assign out_valid = valid_r[NUM_STAGES-1];

  // Date path: b, c estimate, c fix, d and b - d, e estimate, e fix + outputs
  mjdc_date_pipe u_date (
    .clk          (clk),
    .ld           (ld),
    .mjd_days     (in_mjd_days),
    .year         (out_year),
    .month        (out_month),
    .day_of_month (out_day_of_month)
  );

  // Time path: 24f, 60x, 60x, then two alignment ranks
  mjdc_tod_pipe #(
    .FRACTION_BITS        (FRACTION_BITS),
    .SECOND_FRACTION_BITS (SECOND_FRACTION_BITS)
  ) u_tod (
    .clk          (clk),
    .ld           (ld),
    .day_fraction (in_day_fraction),
    .hour         (out_hour),
    .minute       (out_minute),
    .second_fixed (out_second_fixed)
  );

  // Checks
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&valid_r))
    else $error("input stalled while a stage is empty");

  a_advance : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && valid_r[NUM_STAGES-2]) |=> out_valid)
    else $error("beat lost between last two stages");

  a_month_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_month >= 4'd1 && out_month <= 4'd12))
    else $error("month out of range");

  a_time_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_hour <= 5'd23 && out_minute <= 6'd59))
    else $error("hour or minute out of range");

endmodule

`default_nettype wire

/* rtl/core/mjdc_date_pipe.sv */
// ----------------------------------------------------------------------------
// mjdc_date_pipe
// Five-stage datapath: whole MJD days to Gregorian year, month and day.
// ----------------------------------------------------------------------------
`default_nettype none

module mjdc_date_pipe (
  input  logic                                  clk,
  input  mjdc_pkg::mjdc_load_t                  ld,
  input  logic [mjdc_pkg::DAYS_W-1:0]           mjd_days,
  output logic [mjdc_pkg::YEAR_W-1:0]           year,
  output logic [mjdc_pkg::MONTH_W-1:0]          month,
  output logic [mjdc_pkg::DOM_W-1:0]            day_of_month
);
  import mjdc_pkg::*;

  // stage 1: b, 100b - 12210, reciprocal estimate of c
  logic [B_W-1:0]  b_s0;
  logic [N_W-1:0]  n_s0;
  logic [44:0]     cprod_s0;
  logic [B_W-1:0]  b1_r;
  logic [N_W-1:0]  n1_r;
  logic [C_W-1:0]  q1_r;

  assign b_s0     = B_W'(mjd_days) + B_OFFSET;
  assign n_s0     = N_W'(b_s0) * N_W'(100) - C_NUM_OFFSET;
  assign cprod_s0 = 45'(n_s0) * 45'(C_RECIP);

  always_ff @(posedge clk) begin
    if (ld.stage[0]) begin
      b1_r <= b_s0;
      n1_r <= n_s0;
      q1_r <= cprod_s0[44:32];
    end
  end

  // stage 2: correct c by one
  logic [N_W-1:0] r_s1;
  logic [C_W-1:0] c_s1;
  logic [B_W-1:0] b2_r;
  logic [C_W-1:0] c2_r;

  assign r_s1 = n1_r - N_W'(q1_r) * C_DIV;
  assign c_s1 = q1_r + C_W'(r_s1 >= C_DIV);

  always_ff @(posedge clk) begin
    if (ld.stage[1]) begin
      b2_r <= b1_r;
      c2_r <= c_s1;
    end
  end

  // stage 3: d = floor(1461c / 4), g = b - d
  logic [23:0]    dfull_s2;
  logic [B_W-1:0] gdiff_s2;
  logic [G_W-1:0] g3_r;
  logic [C_W-1:0] c3_r;

  assign dfull_s2 = 24'(c2_r) * 24'd1461;
  assign gdiff_s2 = b2_r - B_W'(dfull_s2 >> 2);

  always_ff @(posedge clk) begin
    if (ld.stage[2]) begin
      g3_r <= gdiff_s2[G_W-1:0];
      c3_r <= c2_r;
    end
  end

  // stage 4: reciprocal estimate of e
  logic [36:0]    eprod_s3;
  logic [E_W-1:0] e4_r;
  logic [G_W-1:0] g4_r;
  logic [C_W-1:0] c4_r;

  assign eprod_s3 = 37'(g3_r) * 37'(E_RECIP_K);

  always_ff @(posedge clk) begin
    if (ld.stage[3]) begin
      e4_r <= eprod_s3[35:32];
      g4_r <= g3_r;
      c4_r <= c3_r;
    end
  end

  // stage 5: correct e, then day, month, year
  logic [ET_W-1:0]    er_s4;
  logic [E_W-1:0]     e_s4;
  logic [G_W-1:0]     dd_s4;
  logic [MONTH_W-1:0] mon_s4;
  logic [C_W-1:0]     yy_s4;
  logic [YEAR_W-1:0]  year_r;
  logic [MONTH_W-1:0] month_r;
  logic [DOM_W-1:0]   dom_r;

  assign er_s4  = ET_W'(g4_r) * ET_W'(10000) - ET_W'(e4_r) * E_DIV;
  assign e_s4   = e4_r + E_W'(er_s4 >= E_DIV);
  assign dd_s4  = g4_r - mjdc_day_offset(e_s4);
  assign mon_s4 = (e_s4 < 4'd14) ? (e_s4 - 4'd1) : (e_s4 - 4'd13);
  assign yy_s4  = c4_r - YEAR_OFFSET - C_W'(mon_s4 > 4'd2);

  always_ff @(posedge clk) begin
    if (ld.stage[4]) begin
      year_r  <= yy_s4[YEAR_W-1:0];
      month_r <= mon_s4;
      dom_r   <= dd_s4[DOM_W-1:0];
    end
  end

  assign year         = year_r;
  assign month        = month_r;
  assign day_of_month = dom_r;

endmodule

`default_nettype wire

/* rtl/core/mjdc_tod_pipe.sv */
// ----------------------------------------------------------------------------
// mjdc_tod_pipe
// Five-stage datapath: day fraction to hour, minute and fixed-point seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module mjdc_tod_pipe #(
  parameter int FRACTION_BITS        = 32,
  parameter int SECOND_FRACTION_BITS = 20
) (
  input  logic                           clk,
  input  mjdc_pkg::mjdc_load_t           ld,
  input  logic [mjdc_pkg::DFRAC_W-1:0]   day_fraction,
  output logic [mjdc_pkg::HOUR_W-1:0]    hour,
  output logic [mjdc_pkg::MINUTE_W-1:0]  minute,
  output logic [mjdc_pkg::SEC_W-1:0]     second_fixed
);
  import mjdc_pkg::*;

  localparam int FB  = FRACTION_BITS;
  localparam int T1W = FB + 5;
  localparam int T2W = FB + 6;
  localparam int XW  = T2W + SECOND_FRACTION_BITS;

  // stage 1: 24 f
  logic [FB-1:0]     f_s0;
  logic [T1W-1:0]    t1_s0;
  logic [HOUR_W-1:0] hour1_r;
  logic [FB-1:0]     rem1_r;

  assign f_s0  = FB'(day_fraction);
  assign t1_s0 = T1W'(f_s0) * T1W'(24);

  always_ff @(posedge clk) begin
    if (ld.stage[0]) begin
      hour1_r <= t1_s0[T1W-1:FB];
      rem1_r  <= t1_s0[FB-1:0];
    end
  end

  // stage 2: 60 x remainder -> minute
  logic [T2W-1:0]      t2_s1;
  logic [HOUR_W-1:0]   hour2_r;
  logic [MINUTE_W-1:0] min2_r;
  logic [FB-1:0]       rem2_r;

  assign t2_s1 = T2W'(rem1_r) * T2W'(60);

  always_ff @(posedge clk) begin
    if (ld.stage[1]) begin
      hour2_r <= hour1_r;
      min2_r  <= t2_s1[T2W-1:FB];
      rem2_r  <= t2_s1[FB-1:0];
    end
  end

  // stage 3: 60 x remainder, rescaled to 2^-SECOND_FRACTION_BITS s
  logic [T2W-1:0]      x_s2;
  logic [XW-1:0]       xs_s2;
  logic [HOUR_W-1:0]   hour3_r;
  logic [MINUTE_W-1:0] min3_r;
  logic [SEC_W-1:0]    sec3_r;

  assign x_s2  = T2W'(rem2_r) * T2W'(60);
  assign xs_s2 = (XW'(x_s2) << SECOND_FRACTION_BITS) >> FB;

  always_ff @(posedge clk) begin
    if (ld.stage[2]) begin
      hour3_r <= hour2_r;
      min3_r  <= min2_r;
      sec3_r  <= SEC_W'(xs_s2);
    end
  end

  // stages 4 and 5: align with the date path
  logic [HOUR_W-1:0]   hour4_r, hour5_r;
  logic [MINUTE_W-1:0] min4_r, min5_r;
  logic [SEC_W-1:0]    sec4_r, sec5_r;

  always_ff @(posedge clk) begin
    if (ld.stage[3]) begin
      hour4_r <= hour3_r;
      min4_r  <= min3_r;
      sec4_r  <= sec3_r;
    end
    if (ld.stage[4]) begin
      hour5_r <= hour4_r;
      min5_r  <= min4_r;
      sec5_r  <= sec4_r;
    end
  end

  assign hour         = hour5_r;
  assign minute       = min5_r;
  assign second_fixed = sec5_r;

endmodule

`default_nettype wire
